FILE: rtl/heat_colorize_and_blend_top_assert.svh
// Assertion macros for the heat colorize and blend checker.
`ifndef HEAT_COLORIZE_AND_BLEND_TOP_ASSERT_SVH
`define HEAT_COLORIZE_AND_BLEND_TOP_ASSERT_SVH

// checked outside reset
`define HCB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hcb assertion failed");

// checked at every edge, reset included
`define HCB_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hcb reset assertion failed");

`endif

FILE: rtl/hcb_pkg.sv
// Shared types, constants and arithmetic helpers for the heat colorize and blend block.
`default_nettype none

package hcb_pkg;

  localparam int HEAT_FRAC_BITS = 16;
  localparam int HEAT_W         = HEAT_FRAC_BITS + 1;
  localparam int HEAT_ONE_INT   = 1 << HEAT_FRAC_BITS;
  localparam logic [HEAT_W-1:0] HEAT_ONE    = HEAT_W'(HEAT_ONE_INT);
  localparam logic [HEAT_W-1:0] HEAT_HALF   = HEAT_W'(HEAT_ONE_INT / 2);
  localparam logic [HEAT_W-1:0] HEAT_THRESH = HEAT_W'((HEAT_ONE_INT + 9999) / 10000);

  localparam int COLOR_W    = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (HEAT_W > COLOR_W) ? HEAT_W : COLOR_W;

  localparam logic [HEAT_W-1:0]  MAXT_RESET      = HEAT_W'(29491);
  localparam logic [COLOR_W-1:0] LOW_COLOR_RESET  = 24'hAAFFFF;
  localparam logic [COLOR_W-1:0] HIGH_COLOR_RESET = 24'h00FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_TRANSPARENCY = 2'd0,
    REG_LOW_HEAT_COLOR   = 2'd1,
    REG_HIGH_HEAT_COLOR  = 2'd2
  } cfg_reg_t;

  // pipeline stages, accept to output register
  localparam int STG_MIX    = 0;
  localparam int STG_SECTOR = 1;
  localparam int STG_PROD   = 2;
  localparam int STG_QT     = 3;
  localparam int STG_RECIP  = 4;
  localparam int STG_SELECT = 5;
  localparam int STG_BLEND  = 6;
  localparam int NSTAGE     = 7;

  localparam int MIX_W = HEAT_W + 9;

  localparam logic [7:0]  FULL      = 8'd255;
  localparam logic [15:0] FULL_SQ   = 16'd65025;
  localparam logic [16:0] HALF_FULL = 17'd127;
  localparam logic [24:0] HALF_SQ   = 25'd32512;
  // x/255 ~ (x*257)>>16, x/65025 ~ (x*258)>>24, both low by at most one
  localparam logic [8:0]  RECIP_FULL    = 9'd257;
  localparam logic [8:0]  RECIP_FULL_SQ = 9'd258;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } bgr_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_t;

  typedef struct packed {
    bgr_t              pix;
    logic [HEAT_W-1:0] weight;
    logic              tint;
  } side_t;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] valid;
  } pipe_ctl_t;

  function automatic logic [7:0] mix_round(input logic [7:0] a, input logic [7:0] b,
                                           input logic [HEAT_W-1:0] w);
    logic [MIX_W-1:0] acc;
    logic [MIX_W-1:0] q;
    acc = MIX_W'(HEAT_ONE - w) * MIX_W'(a) + MIX_W'(w) * MIX_W'(b) + MIX_W'(HEAT_HALF);
    q = acc >> HEAT_FRAC_BITS;
    return (q > MIX_W'(FULL)) ? FULL : q[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hcb_ifs.sv
// Stream and configuration channel interfaces of the heat colorize and blend block.
`default_nettype none

interface hcb_pix_if import hcb_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [7:0]        pixel_blue;
  logic [7:0]        pixel_green;
  logic [7:0]        pixel_red;
  logic [HEAT_W-1:0] heat_level;

  modport source (output valid, pixel_blue, pixel_green, pixel_red, heat_level,
                  input ready);
  modport sink (input valid, pixel_blue, pixel_green, pixel_red, heat_level,
                output ready);
endinterface

interface hcb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic       was_tinted;

  modport source (output valid, out_blue, out_green, out_red, was_tinted, input ready);
  modport sink (input valid, out_blue, out_green, out_red, was_tinted, output ready);
endinterface

interface hcb_cfg_if import hcb_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/hcb_pipe_ctrl.sv
// Stage valid bits and per-stage load enables with bubble collapsing.
`default_nettype none

module hcb_pipe_ctrl import hcb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_ready,
  output logic      in_ready,
  output pipe_ctl_t ctl
);

  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] valid_next;
  logic [NSTAGE-1:0] en;

  always_comb begin
    en[NSTAGE-1] = !valid[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
    for (int k = 0; k < NSTAGE; k++) begin
      if (en[k]) begin
        valid_next[k] = (k == 0) ? in_valid : valid[(k == 0) ? 0 : k - 1];
      end else begin
        valid_next[k] = valid[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  assign in_ready = en[0];
  assign ctl      = '{en: en, valid: valid};

endmodule

`default_nettype wire

FILE: rtl/hcb_mix.sv
// Heat clamp, threshold, blend weight and HSV mix between the low and high colors.
`default_nettype none

module hcb_mix import hcb_pkg::*; (
  input  logic               clk,
  input  pipe_ctl_t          ctl,
  input  bgr_t               pix_in,
  input  logic [HEAT_W-1:0]  heat,
  input  logic [HEAT_W-1:0]  max_transparency,
  input  logic [COLOR_W-1:0] low_heat_color,
  input  logic [COLOR_W-1:0] high_heat_color,
  output hsv_t               hsv,
  output side_t              side
);

  logic [HEAT_W-1:0] heat_c;
  logic [HEAT_W-1:0] mt_c;
  logic [HEAT_W-1:0] weight;

  always_comb begin
    heat_c = (heat > HEAT_ONE) ? HEAT_ONE : heat;
    mt_c   = (max_transparency > HEAT_ONE) ? HEAT_ONE : max_transparency;
    weight = (heat_c < mt_c) ? heat_c : mt_c;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[STG_MIX]) begin
      hsv.hue     <= mix_round(low_heat_color[23:16], high_heat_color[23:16], heat_c);
      hsv.sat     <= mix_round(low_heat_color[15:8], high_heat_color[15:8], heat_c);
      hsv.val     <= mix_round(low_heat_color[7:0], high_heat_color[7:0], heat_c);
      side.pix    <= pix_in;
      side.weight <= weight;
      side.tint   <= (heat_c > HEAT_THRESH);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hcb_hsv.sv
// Six-sector HSV to BGR conversion over five stages with rounded constant divides.
`default_nettype none

module hcb_hsv import hcb_pkg::*; (
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  hsv_t      hsv_in,
  input  side_t     side_in,
  output bgr_t      color,
  output side_t     side_out
);

  // sector and remainder
  logic [10:0] h6;
  logic [2:0]  idx;
  logic [10:0] f_full;
  sector_t     sector;

  side_t       s2_side;
  hsv_t        s2_hsv;
  sector_t     s2_sector;
  logic [7:0]  s2_f;

  always_comb begin
    h6  = 11'(hsv_in.hue) * 11'd6;
    idx = 3'd0;
    for (int k = 1; k <= 6; k++) begin
      if (h6 >= 11'(255 * k)) begin
        idx = 3'(k);
      end
    end
    f_full = h6 - 11'(idx) * 11'(FULL);
    sector = (idx > 3'(SEC_5)) ? SEC_5 : sector_t'(idx);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[STG_SECTOR]) begin
      s2_side   <= side_in;
      s2_hsv    <= hsv_in;
      s2_sector <= sector;
      s2_f      <= f_full[7:0];
    end
  end

  // products
  side_t       s3_side;
  logic [7:0]  s3_val;
  sector_t     s3_sector;
  logic [15:0] s3_pnum;
  logic [15:0] s3_sf;
  logic [15:0] s3_sg;

  always_ff @(posedge clk) begin
    if (ctl.en[STG_PROD]) begin
      s3_side   <= s2_side;
      s3_val    <= s2_hsv.val;
      s3_sector <= s2_sector;
      s3_pnum   <= 16'(s2_hsv.val) * 16'(FULL - s2_hsv.sat);
      s3_sf     <= 16'(s2_hsv.sat) * 16'(s2_f);
      s3_sg     <= 16'(s2_hsv.sat) * 16'(FULL - s2_f);
    end
  end

  // q and t numerators, p reciprocal
  logic [16:0] px;
  logic [24:0] pprod;

  side_t       s4_side;
  logic [7:0]  s4_val;
  sector_t     s4_sector;
  logic [16:0] s4_px;
  logic [8:0]  s4_pq0;
  logic [23:0] s4_qnum;
  logic [23:0] s4_tnum;

  always_comb begin
    px    = 17'(s3_pnum) + HALF_FULL;
    pprod = 25'(px) * 25'(RECIP_FULL);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[STG_QT]) begin
      s4_side   <= s3_side;
      s4_val    <= s3_val;
      s4_sector <= s3_sector;
      s4_px     <= px;
      s4_pq0    <= pprod[24:16];
      s4_qnum   <= 24'(s3_val) * 24'(FULL_SQ - s3_sf);
      s4_tnum   <= 24'(s3_val) * 24'(FULL_SQ - s3_sg);
    end
  end

  // q and t reciprocals, p correction
  logic [24:0] qx;
  logic [24:0] tx;
  logic [33:0] qprod;
  logic [33:0] tprod;
  logic [16:0] prem;
  logic [8:0]  pfix;

  side_t       s5_side;
  logic [7:0]  s5_val;
  sector_t     s5_sector;
  logic [7:0]  s5_p;
  logic [24:0] s5_qx;
  logic [24:0] s5_tx;
  logic [8:0]  s5_qq0;
  logic [8:0]  s5_tq0;

  always_comb begin
    qx    = 25'(s4_qnum) + HALF_SQ;
    tx    = 25'(s4_tnum) + HALF_SQ;
    qprod = 34'(qx) * 34'(RECIP_FULL_SQ);
    tprod = 34'(tx) * 34'(RECIP_FULL_SQ);
    prem  = s4_px - 17'(s4_pq0) * 17'(FULL);
    pfix  = s4_pq0 + 9'(prem >= 17'(FULL));
  end

  always_ff @(posedge clk) begin
    if (ctl.en[STG_RECIP]) begin
      s5_side   <= s4_side;
      s5_val    <= s4_val;
      s5_sector <= s4_sector;
      s5_p      <= (pfix > 9'(FULL)) ? FULL : pfix[7:0];
      s5_qx     <= qx;
      s5_tx     <= tx;
      s5_qq0    <= qprod[32:24];
      s5_tq0    <= tprod[32:24];
    end
  end

  // q and t correction, sector select
  logic [24:0] qrem;
  logic [24:0] trem;
  logic [8:0]  qfix;
  logic [8:0]  tfix;
  logic [7:0]  q;
  logic [7:0]  t;
  bgr_t        sel;

  always_comb begin
    qrem = s5_qx - 25'(s5_qq0) * 25'(FULL_SQ);
    trem = s5_tx - 25'(s5_tq0) * 25'(FULL_SQ);
    qfix = s5_qq0 + 9'(qrem >= 25'(FULL_SQ));
    tfix = s5_tq0 + 9'(trem >= 25'(FULL_SQ));
    q    = (qfix > 9'(FULL)) ? FULL : qfix[7:0];
    t    = (tfix > 9'(FULL)) ? FULL : tfix[7:0];
    case (s5_sector)
      SEC_0:   sel = '{blue: s5_p,   green: t,      red: s5_val};
      SEC_1:   sel = '{blue: s5_p,   green: s5_val, red: q};
      SEC_2:   sel = '{blue: t,      green: s5_val, red: s5_p};
      SEC_3:   sel = '{blue: s5_val, green: q,      red: s5_p};
      SEC_4:   sel = '{blue: s5_val, green: s5_p,   red: t};
      default: sel = '{blue: q,      green: s5_p,   red: s5_val};
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en[STG_SELECT]) begin
      color    <= sel;
      side_out <= s5_side;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hcb_blend.sv
// Weighted blend of the heat color over the pixel, or pass-through, into the output register.
`default_nettype none

module hcb_blend import hcb_pkg::*; (
  input  logic      clk,
  input  pipe_ctl_t ctl,
  input  bgr_t      color,
  input  side_t     side,
  output bgr_t      res_pix,
  output logic      res_tint
);

  bgr_t mixed;

  always_comb begin
    if (side.tint) begin
      mixed.blue  = mix_round(side.pix.blue, color.blue, side.weight);
      mixed.green = mix_round(side.pix.green, color.green, side.weight);
      mixed.red   = mix_round(side.pix.red, color.red, side.weight);
    end else begin
      mixed = side.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[STG_BLEND]) begin
      res_pix  <= mixed;
      res_tint <= side.tint;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/heat_colorize_and_blend_top.sv
// Top level of the heat colorize and blend block: config registers and the seven-stage pipe.
`default_nettype none

// Tints a BGR pixel by its heat level: heat is mixed in HSV between two
// programmable colors, converted to BGR and blended over the pixel with
// weight min(heat, max_transparency); heat at or below the threshold passes
// the pixel through. One pixel per clock sustained while results are taken; each
// stage loads whenever it is empty or its successor moves, so bubbles close up
// and a stalled output holds only what is behind it. Configuration writes are
// always taken and reach every pixel accepted after the write; beats already
// in the pipe keep the old settings.

module heat_colorize_and_blend_top import hcb_pkg::*; (
  input logic      clk,
  input logic      rst,
  hcb_pix_if.sink  pixel,
  hcb_res_if.source result,
  hcb_cfg_if.sink  cfg
);

  logic [HEAT_W-1:0]  max_transparency;
  logic [COLOR_W-1:0] low_heat_color;
  logic [COLOR_W-1:0] high_heat_color;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_transparency <= MAXT_RESET;
      low_heat_color   <= LOW_COLOR_RESET;
      high_heat_color  <= HIGH_COLOR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_MAX_TRANSPARENCY: max_transparency <= cfg.data[HEAT_W-1:0];
        REG_LOW_HEAT_COLOR:   low_heat_color   <= cfg.data[COLOR_W-1:0];
        REG_HIGH_HEAT_COLOR:  high_heat_color  <= cfg.data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  pipe_ctl_t ctl;
  logic      in_ready;
  bgr_t      pix_in;
  hsv_t      hsv;
  side_t     mix_side;
  bgr_t      color;
  side_t     hsv_side;
  bgr_t      res_pix;
  logic      res_tint;

  assign pix_in = '{blue: pixel.pixel_blue, green: pixel.pixel_green, red: pixel.pixel_red};

  hcb_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel.valid),
    .out_ready (result.ready),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  hcb_mix u_mix (
    .clk              (clk),
    .ctl              (ctl),
    .pix_in           (pix_in),
    .heat             (pixel.heat_level),
    .max_transparency (max_transparency),
    .low_heat_color   (low_heat_color),
    .high_heat_color  (high_heat_color),
    .hsv              (hsv),
    .side             (mix_side)
  );

  hcb_hsv u_hsv (
    .clk      (clk),
    .ctl      (ctl),
    .hsv_in   (hsv),
    .side_in  (mix_side),
    .color    (color),
    .side_out (hsv_side)
  );

  hcb_blend u_blend (
    .clk      (clk),
    .ctl      (ctl),
    .color    (color),
    .side     (hsv_side),
    .res_pix  (res_pix),
    .res_tint (res_tint)
  );

  assign pixel.ready       = in_ready;
  assign result.valid      = ctl.valid[STG_BLEND];
  assign result.out_blue   = res_pix.blue;
  assign result.out_green  = res_pix.green;
  assign result.out_red    = res_pix.red;
  assign result.was_tinted = res_tint;

endmodule

`default_nettype wire

FILE: rtl/hcb_checker.sv
// Port-level checks of the heat colorize and blend top, bound to it.
`default_nettype none

`include "heat_colorize_and_blend_top_assert.svh"

module hcb_checker import hcb_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_blue,
  input logic [7:0] res_green,
  input logic [7:0] res_red,
  input logic       res_tint
);

  localparam int CNT_W = $clog2(NSTAGE + 2);

  logic [CNT_W-1:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CNT_W'(in_valid && in_ready) - CNT_W'(res_valid && res_ready);
    end
  end

  `HCB_ASSERT_RST(a_reset_empty, rst |=> !res_valid)
  `HCB_ASSERT(a_hold, res_valid && !res_ready |=> res_valid && $stable(res_blue) && $stable(res_green) && $stable(res_red) && $stable(res_tint))
  `HCB_ASSERT(a_depth, inflight <= CNT_W'(NSTAGE))
  `HCB_ASSERT(a_no_phantom, res_valid |-> inflight != '0)

endmodule

bind heat_colorize_and_blend_top hcb_checker u_hcb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel.valid),
  .in_ready  (pixel.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .res_blue  (result.out_blue),
  .res_green (result.out_green),
  .res_red   (result.out_red),
  .res_tint  (result.was_tinted)
);

`default_nettype wire
